[rtl/b64d_pkg.sv]
package b64d_pkg;

   localparam int unsigned SEXTET_W = 6;
   localparam int unsigned WORD_W   = 24;
   localparam int unsigned BUF_W    = 18;
   localparam int unsigned GCNT_W   = 2;
   localparam int unsigned NCNT_W   = 2;
   localparam int unsigned BYTE_W   = 8;

   localparam logic [GCNT_W-1:0] GCNT_FULL = 2'd3;

   // one queued decode job: a 24-bit word and how many of its top bytes go out
   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic [NCNT_W-1:0] count;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   typedef struct packed {
      logic                ok;
      logic [SEXTET_W-1:0] value;
   } sextet_type;

   function automatic sextet_type sextet_of(input logic [7:0] c);
      sextet_type r;
      logic [7:0] v;
      r.ok    = 1'b1;
      v       = 8'd0;
      if (c inside {[8'h41:8'h5A]}) begin
         v = c - 8'h41;
      end else if (c inside {[8'h61:8'h7A]}) begin
         v = c - 8'h61 + 8'd26;
      end else if (c inside {[8'h30:8'h39]}) begin
         v = c - 8'h30 + 8'd52;
      end else if (c == 8'h2B) begin
         v = 8'd62;
      end else if (c == 8'h2F) begin
         v = 8'd63;
      end else begin
         r.ok = 1'b0;
      end
      r.value = v[SEXTET_W-1:0];
      return r;
   endfunction

endpackage

[rtl/base64_stream_decoder_unit.sv]
// with the output idle, the first byte of a group is queued by the character that completes
// or flushes its group, then loaded into the output register, and leaves from there
// throughput: one character per cycle while the job queue has room; the output sends one
// byte per cycle while rsp_stall is low, and a full group of 4 characters gives 3 bytes,
// so it keeps up; the front stalls only when the QUEUE_DEPTH-entry job queue is full
// reset (synchronous, active high) empties the queue and clears the pending group
module base64_stream_decoder_unit #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_code,
   input  logic       req_end_of_input,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_last_of_run
);

   logic                push;
   logic                pop;
   b64d_pkg::job_type   push_job;
   b64d_pkg::job_type   head_job;
   b64d_pkg::qstat_type qstat;

   b64d_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_char_code    (req_char_code),
      .req_end_of_input (req_end_of_input),
      .qstat            (qstat),
      .push             (push),
      .push_job         (push_job)
   );

   b64d_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .qstat    (qstat)
   );

   b64d_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_job        (head_job),
      .qstat           (qstat),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

[rtl/b64d_front.sv]
module b64d_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_char_code,
   input  logic                   req_end_of_input,
   input  b64d_pkg::qstat_type    qstat,
   output logic                   push,
   output b64d_pkg::job_type      push_job
);

   logic [b64d_pkg::BUF_W-1:0]  buf_ff, buf_in;
   logic [b64d_pkg::GCNT_W-1:0] gcnt_ff, gcnt_in;
   logic                        take;

   assign req_stall = qstat.full;
   assign take      = req_valid && !req_stall;

   always_comb begin
      b64d_pkg::sextet_type        sx;
      logic [b64d_pkg::BUF_W-1:0]  nbuf;
      logic [b64d_pkg::GCNT_W-1:0] ncnt;
      sx            = b64d_pkg::sextet_of(req_char_code);
      nbuf          = buf_ff;
      ncnt          = gcnt_ff;
      push_job.word  = '0;
      push_job.count = '0;
      if (sx.ok) begin
         if (gcnt_ff == b64d_pkg::GCNT_FULL) begin
            push_job.word  = {buf_ff, sx.value};
            push_job.count = 2'd3;
            nbuf           = '0;
            ncnt           = '0;
         end else begin
            nbuf = {buf_ff[b64d_pkg::BUF_W-b64d_pkg::SEXTET_W-1:0], sx.value};
            ncnt = gcnt_ff + 2'd1;
         end
      end
      if (req_end_of_input) begin
         // flush a partial group, missing sextets read as zero
         if (ncnt == 2'd2) begin
            push_job.word  = {nbuf[11:0], 12'd0};
            push_job.count = 2'd1;
         end else if (ncnt == 2'd3) begin
            push_job.word  = {nbuf, 6'd0};
            push_job.count = 2'd2;
         end
         nbuf = '0;
         ncnt = '0;
      end
      if (take) begin
         buf_in  = nbuf;
         gcnt_in = ncnt;
      end else begin
         buf_in  = buf_ff;
         gcnt_in = gcnt_ff;
      end
   end

   assign push = take && (push_job.count != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff  <= '0;
         gcnt_ff <= '0;
      end else begin
         buf_ff  <= buf_in;
         gcnt_ff <= gcnt_in;
      end
   end

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      take && req_end_of_input |=> gcnt_ff == '0)
      else $error("group not cleared after end of input");

endmodule

[rtl/b64d_queue.sv]
module b64d_queue #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  b64d_pkg::job_type   push_job,
   input  logic                pop,
   output b64d_pkg::job_type   head_job,
   output b64d_pkg::qstat_type qstat
);

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

   b64d_pkg::job_type  mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   assign qstat.full  = (cnt_ff == CNT_W'(QUEUE_DEPTH));
   assign qstat.empty = (cnt_ff == '0);
   assign head_job    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !qstat.full || pop)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !qstat.empty)
      else $error("pop from empty queue");

endmodule

[rtl/b64d_back.sv]
module b64d_back (
   input  logic                clock,
   input  logic                reset,
   input  b64d_pkg::job_type   head_job,
   input  b64d_pkg::qstat_type qstat,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_data_byte,
   output logic                rsp_last_of_run
);

   logic                          cur_valid_ff, cur_valid_in;
   b64d_pkg::job_type             cur_job_ff, cur_job_in;
   logic [b64d_pkg::NCNT_W-1:0]   idx_ff, idx_in;
   logic                          sent;
   logic                          load;

   assign rsp_valid       = cur_valid_ff;
   assign rsp_last_of_run = (idx_ff == cur_job_ff.count - 2'd1);
   assign sent            = rsp_valid && !rsp_stall;
   // take the next job once the current one is gone or its last byte leaves
   assign load            = !cur_valid_ff || (sent && rsp_last_of_run);
   assign pop             = load && !qstat.empty;

   always_comb begin
      case (idx_ff)
         2'd0:    rsp_data_byte = cur_job_ff.word[23:16];
         2'd1:    rsp_data_byte = cur_job_ff.word[15:8];
         2'd2:    rsp_data_byte = cur_job_ff.word[7:0];
         default: rsp_data_byte = cur_job_ff.word[7:0];
      endcase
   end

   always_comb begin
      cur_valid_in = cur_valid_ff;
      cur_job_in   = cur_job_ff;
      idx_in       = idx_ff;
      if (load) begin
         cur_valid_in = !qstat.empty;
         cur_job_in   = head_job;
         idx_in       = '0;
      end else if (sent) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      cur_job_ff <= cur_job_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
      end
   end

   a_job_nonempty: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> cur_job_ff.count != '0)
      else $error("empty job in output stage");

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> idx_ff < cur_job_ff.count)
      else $error("byte index past job length");

endmodule

[bench/b64_decode_checker.sv]
module b64_decode_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_char_code,
   input  logic       req_end_of_input,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [7:0] rsp_data_byte,
   input  logic       rsp_last_of_run,
   output int         error_count,
   output int         pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_of_run;
   } decoded_byte_type;

   decoded_byte_type expected_bytes[$];

   // sextets of the group in progress, oldest in the top bits
   logic [17:0] held_sextets = '0;
   logic [1:0]  held_count = '0;

   function automatic logic lookup_sextet(input logic [7:0] ch, output logic [5:0] value);
      logic hit;
      hit = 1'b1;
      value = '0;
      if (ch >= "A" && ch <= "Z") begin
         value = 6'(ch - "A");
      end else if (ch >= "a" && ch <= "z") begin
         value = 6'(ch - "a" + 8'd26);
      end else if (ch >= "0" && ch <= "9") begin
         value = 6'(ch - "0" + 8'd52);
      end else if (ch == "+") begin
         value = 6'd62;
      end else if (ch == "/") begin
         value = 6'd63;
      end else begin
         hit = 1'b0;
      end
      return hit;
   endfunction

   // top bytes of the word go out first, the final one flagged
   task automatic queue_bytes(input logic [23:0] word, input int count);
      decoded_byte_type entry;
      int k;
      for (k = 0; k < count; k++) begin
         entry.data_byte = word[23 - 8 * k -: 8];
         entry.last_of_run = (k == count - 1);
         expected_bytes.push_back(entry);
      end
   endtask

   task automatic decode_char(input logic [7:0] ch, input logic eoi);
      logic [5:0]  sextet;
      logic [23:0] word;
      if (lookup_sextet(ch, sextet)) begin
         if (held_count == 2'd3) begin
            queue_bytes({held_sextets, sextet}, 3);
            held_sextets = '0;
            held_count = '0;
         end else begin
            held_sextets = {held_sextets[11:0], sextet};
            held_count = held_count + 2'd1;
         end
      end
      if (eoi) begin
         // partial group: missing sextets are zero, k sextets give k-1 bytes
         if (held_count >= 2'd2) begin
            word = 24'(held_sextets) << (6 * (4 - int'(held_count)));
            queue_bytes(word, int'(held_count) - 1);
         end
         held_sextets = '0;
         held_count = '0;
      end
   endtask

   always @(posedge clock) begin
      decoded_byte_type want;
      if (reset) begin
         expected_bytes.delete();
         held_sextets = '0;
         held_count = '0;
      end else begin
         if (req_valid && !req_stall) begin
            decode_char(req_char_code, req_end_of_input);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_bytes.size() == 0) begin
               $display("%0t: unexpected transaction, expected none, %s %02h %s %b",
                        $time, "actual data_byte", rsp_data_byte, "last_of_run",
                        rsp_last_of_run);
               error_count = error_count + 1;
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_data_byte !== want.data_byte) begin
                  $display("%0t: data_byte mismatch, expected %02h actual %02h",
                           $time, want.data_byte, rsp_data_byte);
                  error_count = error_count + 1;
               end
               if (rsp_last_of_run !== want.last_of_run) begin
                  $display("%0t: last_of_run mismatch, expected %b actual %b",
                           $time, want.last_of_run, rsp_last_of_run);
                  error_count = error_count + 1;
               end
            end
         end
      end
      pending_count <= expected_bytes.size();
   end

endmodule

[bench/testbench.sv]
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLOCK_PERIOD = 20;
   localparam int LONG_HOLD = 400;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int ITEMS_PER_PHASE = 95;
   localparam int DRAIN_CYCLES = 10;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_char_code = 8'h00;
   logic       req_end_of_input = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_data_byte;
   logic       rsp_last_of_run;

   int error_count;
   int pending_count;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_asks = 0;
   int holds_done = 0;
   int quiet_cycles = 0;
   int useful_items = 0;

   int idle_pcts[4] = '{0, 55, 0, 36};
   int stall_pcts[4] = '{0, 0, 55, 36};

   base64_stream_decoder_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_char_code    (req_char_code),
      .req_end_of_input (req_end_of_input),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   b64_decode_checker checker_inst (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_char_code    (req_char_code),
      .req_end_of_input (req_end_of_input),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_last_of_run  (rsp_last_of_run),
      .error_count      (error_count),
      .pending_count    (pending_count)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // receiver: random stalls, or a long hold-off when one is asked for
   initial begin
      forever begin
         @(posedge clock);
         if (holds_done != hold_asks) begin
            holds_done = hold_asks;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic logic [7:0] alphabet_char(input int unsigned value);
      if (value < 26) return 8'("A" + value);
      if (value < 52) return 8'("a" + value - 26);
      if (value < 62) return 8'("0" + value - 52);
      if (value == 62) return "+";
      return "/";
   endfunction

   function automatic logic [7:0] noise_char();
      case ($urandom_range(5))
         0: return " ";
         1: return 8'h0A;
         2: return 8'h0D;
         3: return 8'h09;
         4: return "=";
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   task automatic send_char(input logic [7:0] ch, input logic eoi);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_char_code <= ch;
      req_end_of_input <= eoi;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_text(input string text, input logic eoi_last);
      int i;
      for (i = 0; i < text.len(); i++) begin
         send_char(text[i], eoi_last && (i == text.len() - 1));
      end
   endtask

   // a well-formed stream with random content, some whitespace or other noise characters, and one of several endings
   task automatic send_stream();
      int n_chars;
      int k;
      int ending;
      n_chars = $urandom_range(12);
      ending = $urandom_range(3);
      if (n_chars == 0 && ending == 0) ending = 1;
      for (k = 0; k < n_chars; k++) begin
         if ($urandom_range(9) == 0) send_char(noise_char(), 1'b0);
         send_char(alphabet_char($urandom_range(63)), (k == n_chars - 1) && (ending == 0));
      end
      case (ending)
         1: send_char("=", 1'b1);
         2: send_char(8'h0A, 1'b1);
         3: send_char(8'($urandom_range(255)), 1'b1);
         default: ;
      endcase
      useful_items += n_chars + ((ending != 0) ? 1 : 0);
   endtask

   task automatic send_noise();
      int burst;
      logic eoi;
      burst = $urandom_range(6, 1);
      repeat (burst) begin
         eoi = ($urandom_range(7) == 0);
         send_char(8'($urandom_range(255)), eoi);
         if (eoi) useful_items++;
      end
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin
      int phase_idx;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_text("TWFu", 1'b0);
      send_text("/+90", 1'b0);
      // two sextets then padding carrying the end flag
      send_text("QQ=", 1'b1);
      send_text("QUI", 1'b1);
      // lone sextet at the end gives nothing
      send_text("Z", 1'b1);
      // group completed by the flagged character
      send_text("Az9/", 1'b1);
      send_char(8'h00, 1'b0);
      send_char(8'hFF, 1'b0);
      send_char(8'h0A, 1'b0);
      send_char(8'h80, 1'b1);
      wait_for_drain();

      for (phase_idx = 0; phase_idx < 4; phase_idx++) begin
         send_idle_pct = idle_pcts[phase_idx];
         stall_pct = stall_pcts[phase_idx];
         if (phase_idx == 0 || phase_idx == 3) hold_asks++;
         useful_items = 0;
         while (useful_items < ITEMS_PER_PHASE) begin
            if ($urandom_range(9) < 8) send_stream();
            else send_noise();
         end
         wait_for_drain();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
